// File: hw/rtl/isc_pkg.sv
// ============================================================================
// Indentation stack checker package
// Shared constants, character codes, verdict codes and types.
// ============================================================================
package isc_pkg;

   // Default sizes for the top-level parameters.
   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int INDENT_BITS_DEFAULT = 8;
   localparam int LINE_BITS_DEFAULT   = 16;

   // Field widths fixed by the interface.
   localparam int CHAR_W       = 8;
   localparam int TAB_WIDTH_W  = 4;
   localparam int VERDICT_W    = 2;
   localparam int ERROR_LINE_W = 16;

   // Reset value of the tab width register.
   localparam logic [TAB_WIDTH_W-1:0] TAB_WIDTH_RESET = 4'd4;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_OK       = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_MISINDENT = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_OVERFLOW = 2'd2;

   // Shift command broadcast to every level cell.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_cmd_type;

   // One result transaction.
   typedef struct packed {
      logic [VERDICT_W-1:0]    verdict;
      logic [ERROR_LINE_W-1:0] error_line;
   } result_type;

endpackage

// File: hw/rtl/isc_level_cell.sv
// ============================================================================
// Indentation stack checker level cell
// One entry of the level stack; shifts toward the bottom on a push and
// toward the top on a pop.
// ============================================================================
module isc_level_cell #(
   parameter int INDENT_BITS = isc_pkg::INDENT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  isc_pkg::cell_cmd_type    cmd,
   input  logic [INDENT_BITS-1:0]   push_level,
   input  logic [INDENT_BITS-1:0]   pop_level,
   output logic [INDENT_BITS-1:0]   level
);
   import isc_pkg::*;

   logic [INDENT_BITS-1:0] level_ff;
   logic [INDENT_BITS-1:0] level_in;

   always_comb begin
      level_in = level_ff;
      if (cmd.push) begin
         level_in = push_level;
      end else if (cmd.pop) begin
         level_in = pop_level;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

// File: hw/rtl/isc_result_buffer.sv
// ============================================================================
// Indentation stack checker result buffer
// Output register with one skid entry behind it.
// ============================================================================
module isc_result_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  isc_pkg::result_type   load_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output isc_pkg::result_type   out_data
);
   import isc_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !out_stall) begin
         // Output slot is free or drains this cycle.
         out_valid_in  = skid_valid_ff || load_valid;
         out_data_in   = skid_valid_ff ? skid_data_ff : load_data;
         skid_valid_in = 1'b0;
      end else if (load_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// File: hw/rtl/indentation_stack_checker.sv
// ============================================================================
// Indentation stack checker
// Checks that the leading indentation of a text stream follows a stack of
// levels and reports one verdict per file.
// ============================================================================
// The block takes one character per request transaction and sustains one
// transaction per clock cycle; every character is fully handled in the cycle
// it is accepted. Leading spaces add one to the line's indentation and
// leading tabs add the value of the tab width register, saturating at the
// largest value of INDENT_BITS bits. At each newline the line's level is
// compared with the top of a level stack held in a row of STACK_DEPTH cells:
// a deeper line pushes, a shallower line pops once and must match the new
// top. The first failure is latched with its line number. A transaction with
// end_of_file set checks any unfinished last line and produces exactly one
// response transaction (verdict and error line), then returns the checker to
// its start state. Other transactions produce no response. A response that
// waits on rsp_stall does not hold up the character stream: a second verdict
// goes into a skid entry, and req_stall rises only while two verdicts wait.
// The tab width register may be written only while the block is idle.
// ============================================================================
module indentation_stack_checker #(
   parameter int STACK_DEPTH = isc_pkg::STACK_DEPTH_DEFAULT,
   parameter int INDENT_BITS = isc_pkg::INDENT_BITS_DEFAULT,
   parameter int LINE_BITS   = isc_pkg::LINE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel: one character per transaction.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [isc_pkg::CHAR_W-1:0]         req_char_byte,
   input  logic                               req_end_of_file,
   // Response channel: one verdict per file.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [isc_pkg::VERDICT_W-1:0]      rsp_verdict,
   output logic [isc_pkg::ERROR_LINE_W-1:0]   rsp_error_line,
   // Configuration channel: tab width register.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [isc_pkg::TAB_WIDTH_W-1:0]    csr_tab_width
);
   import isc_pkg::*;

   // The depth counter must be able to hold STACK_DEPTH itself.
   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam logic [DEPTH_W-1:0]     DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
   localparam logic [DEPTH_W-1:0]     DEPTH_ONE  = DEPTH_W'(1);
   localparam logic [INDENT_BITS-1:0] INDENT_MAX = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
   localparam logic [LINE_BITS-1:0]   LINE_FIRST = LINE_BITS'(1);

   // ------------------------------------------------------------------------
   // Control state.
   // ------------------------------------------------------------------------
   logic [TAB_WIDTH_W-1:0] tab_width_ff;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;
   logic                   lead_ff, lead_in;
   logic [INDENT_BITS-1:0] indent_ff, indent_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [VERDICT_W-1:0]   fail_code_ff, fail_code_in;
   logic [LINE_BITS-1:0]   fail_line_ff, fail_line_in;

   logic                   req_accept;
   logic                   is_newline;
   logic                   line_done;
   logic                   buffer_full;
   logic [INDENT_BITS:0]   indent_add;
   logic [INDENT_BITS:0]   indent_sum;
   logic [INDENT_BITS-1:0] indent_sat;

   cell_cmd_type           cell_cmd;
   logic [INDENT_BITS-1:0] level [STACK_DEPTH];

   logic                   result_valid;
   result_type             result_data;
   result_type             rsp_data;
   logic [LINE_BITS+ERROR_LINE_W-1:0] fail_line_ext;

   // The configuration port never pushes back.
   assign csr_ready = 1'b1;

   // Characters keep flowing unless both result slots are occupied.
   assign req_stall  = buffer_full;
   assign req_accept = req_valid && !req_stall;
   assign is_newline = (req_char_byte == CHAR_NEWLINE);

   // A line is checked at a newline, and at end of file when the last line
   // received a non-blank character or counted some indentation.
   assign line_done = req_accept &&
                      (req_end_of_file ? (!lead_ff || (indent_ff != '0)) : is_newline);

   // Saturating indentation accumulator.
   always_comb begin
      indent_add = (req_char_byte == CHAR_TAB) ? (INDENT_BITS + 1)'(tab_width_ff)
                                               : (INDENT_BITS + 1)'(1);
      indent_sum = {1'b0, indent_ff} + indent_add;
      indent_sat = indent_sum[INDENT_BITS] ? INDENT_MAX : indent_sum[INDENT_BITS-1:0];
   end

   // ------------------------------------------------------------------------
   // Stack discipline. Cell 0 is the top of the stack and cell 1 the entry
   // below it, so each check looks only at those two fixed places. After the
   // first failure no further line changes the stack.
   // ------------------------------------------------------------------------
   always_comb begin
      cell_cmd     = '0;
      depth_in     = depth_ff;
      fail_code_in = fail_code_ff;
      fail_line_in = fail_line_ff;
      if (line_done && (fail_code_ff == VERDICT_OK)) begin
         priority if (depth_ff == '0) begin
            // The first line sets the base level.
            cell_cmd.push = 1'b1;
            depth_in      = DEPTH_ONE;
         end else if (indent_ff > level[0]) begin
            if (depth_ff == DEPTH_FULL) begin
               fail_code_in = VERDICT_OVERFLOW;
               fail_line_in = line_ff;
            end else begin
               cell_cmd.push = 1'b1;
               depth_in      = depth_ff + DEPTH_ONE;
            end
         end else if (indent_ff < level[0]) begin
            if (depth_ff == DEPTH_ONE) begin
               // Nothing left to return to below the base level.
               fail_code_in = VERDICT_MISINDENT;
               fail_line_in = line_ff;
            end else begin
               cell_cmd.pop = 1'b1;
               depth_in     = depth_ff - DEPTH_ONE;
               if (level[1] != indent_ff) begin
                  fail_code_in = VERDICT_MISINDENT;
                  fail_line_in = line_ff;
               end
            end
         end else begin
            // Same level as the top: nothing to do.
            cell_cmd = '0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Row of level cells. On a push every cell takes its upper neighbor's
   // level and the top cell takes the finished line's count; on a pop every
   // cell but the bottom one takes its lower neighbor's level; the bottom keeps its own.
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [INDENT_BITS-1:0] push_level;
      logic [INDENT_BITS-1:0] pop_level;

      if (i == 0) begin : g_top
         assign push_level = indent_ff;
      end else begin : g_inner
         assign push_level = level[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign pop_level = level[i];
      end else begin : g_upper
         assign pop_level = level[i+1];
      end

      isc_level_cell #(
         .INDENT_BITS (INDENT_BITS)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .push_level (push_level),
         .pop_level  (pop_level),
         .level      (level[i])
      );
   end

   // ------------------------------------------------------------------------
   // Line scanning and end-of-file clear.
   // ------------------------------------------------------------------------
   always_comb begin
      lead_in   = lead_ff;
      indent_in = indent_ff;
      line_in   = line_ff;
      if (is_newline) begin
         lead_in   = 1'b1;
         indent_in = '0;
         line_in   = (line_ff != LINE_MAX) ? line_ff + LINE_FIRST : line_ff;
      end else if (lead_ff) begin
         if ((req_char_byte == CHAR_TAB) || (req_char_byte == CHAR_SPACE)) begin
            indent_in = indent_sat;
         end else begin
            lead_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff <= TAB_WIDTH_RESET;
         depth_ff     <= '0;
         lead_ff      <= 1'b1;
         indent_ff    <= '0;
         line_ff      <= LINE_FIRST;
         fail_code_ff <= VERDICT_OK;
         fail_line_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            tab_width_ff <= csr_tab_width;
         end
         if (req_accept) begin
            if (req_end_of_file) begin
               depth_ff     <= '0;
               lead_ff      <= 1'b1;
               indent_ff    <= '0;
               line_ff      <= LINE_FIRST;
               fail_code_ff <= VERDICT_OK;
               fail_line_ff <= '0;
            end else begin
               depth_ff     <= depth_in;
               lead_ff      <= lead_in;
               indent_ff    <= indent_in;
               line_ff      <= line_in;
               fail_code_ff <= fail_code_in;
               fail_line_ff <= fail_line_in;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Verdict. It includes the outcome of checking the unfinished last line in
   // the same cycle. The reported line is the low bits of the failing line.
   // ------------------------------------------------------------------------
   assign fail_line_ext = {{ERROR_LINE_W{1'b0}}, fail_line_in};
   assign result_valid  = req_accept && req_end_of_file;

   always_comb begin
      result_data.verdict    = fail_code_in;
      result_data.error_line = (fail_code_in == VERDICT_OK) ? '0
                                                            : fail_line_ext[ERROR_LINE_W-1:0];
   end

   isc_result_buffer u_result (
      .clock      (clock),
      .reset      (reset),
      .load_valid (result_valid),
      .load_data  (result_data),
      .full       (buffer_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

   assign rsp_verdict    = rsp_data.verdict;
   assign rsp_error_line = rsp_data.error_line;

endmodule
